### src/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types, codes, AES tables and helper functions for the GCM engine.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam logic [1:0] OP_AAD  = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;
    localparam logic [1:0] OP_FIN  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] REG_KEY_HI = 3'd0;
    localparam logic [2:0] REG_KEY_LO = 3'd1;
    localparam logic [2:0] REG_IV_HI  = 3'd2;
    localparam logic [2:0] REG_IV_LO  = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;

    localparam logic [4:0] FULL_BYTES = 5'd16;
    localparam logic [3:0] LAST_ROUND = 4'd10;
    localparam logic [3:0] GH_STEPS   = 4'd15;
    localparam logic [7:0] GH_POLY    = 8'he1;

    typedef struct packed {
        logic [1:0]   op;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } t_item;

    typedef struct packed {
        logic [127:0] key;
        logic [95:0]  iv;
        logic         decrypt;
    } t_cfg;

    typedef struct packed {
        logic         kind;
        logic [127:0] data;
        logic [4:0]   nbytes;
        logic         tag_ok;
    } t_result;

    typedef struct packed {
        logic kexp_start;
        logic enc_start;
    } t_aes_ctl;

    typedef struct packed {
        logic kexp_done;
        logic enc_done;
    } t_aes_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_HSUB,
        ST_TMASK,
        ST_CTR,
        ST_HASH,
        ST_OUT
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon_of(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] rnd);
        logic [31:0] t;
        logic [31:0] n0, n1, n2, n3;
        t  = sbox_word({k[23:0], k[31:24]}) ^ {rcon_of(rnd), 24'h0};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // sub bytes, shift rows and, except in the last round, mix columns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int i = 0; i < 16; i++) begin
            t[i] = b[(i + 4 * (i % 4)) % 16];
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
                b[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
                b[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
                b[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                b[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = b[i];
        end
        return r;
    endfunction

    // keeps the first n bytes, n in 1..16
    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [7:0] sh;
        sh = {n, 3'b000};
        return ~({128{1'b1}} >> sh);
    endfunction

endpackage

### src/gcm_front.sv
// ----------------------------------------------------------------------------
// gcm_front
// Input side: takes beats, drops the ones that cause no work, clamps the byte
// count and holds items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gcm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  gcm_pkg::t_item      i_item,
    output logic                o_q_valid,
    output gcm_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);

    gcm_pkg::t_item r_mem [2];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    logic           w_accept;
    logic           w_keep;
    logic           w_push;
    gcm_pkg::t_item w_item;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_accept  = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        w_item = i_item;
        if (i_item.nbytes > gcm_pkg::FULL_BYTES) begin
            w_item.nbytes = gcm_pkg::FULL_BYTES;
        end
        // unused op and empty data blocks are swallowed
        w_keep = (i_item.op == gcm_pkg::OP_FIN) ||
                 ((i_item.op != gcm_pkg::OP_NONE) && (i_item.nbytes != 5'd0));
        w_push = w_accept && w_keep;
        n_wp   = w_push ? ~r_wp : r_wp;
        n_rp   = i_q_pop ? ~r_rp : r_rp;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

### src/gcm_aes.sv
// ----------------------------------------------------------------------------
// gcm_aes
// AES-128 encrypt unit: key schedule one round key per cycle into an
// eleven-row table, then one round per cycle for each block.
// ----------------------------------------------------------------------------
module gcm_aes (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gcm_pkg::t_aes_ctl   i_ctl,
    input  logic [127:0]        i_key,
    input  logic [127:0]        i_blk,
    output gcm_pkg::t_aes_sts   o_sts,
    output logic [127:0]        o_result
);

    logic [127:0] r_rk [11];
    logic [127:0] r_kw;
    logic [127:0] r_st;
    logic [3:0]   r_round;
    logic         r_kbusy;
    logic         r_ebusy;
    logic         r_kdone;
    logic         r_edone;
    logic [127:0] w_knext;

    assign w_knext = gcm_pkg::key_step(r_kw, r_round);
    assign o_sts.kexp_done = r_kdone;
    assign o_sts.enc_done  = r_edone;
    assign o_result        = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbusy <= 1'b0;
            r_ebusy <= 1'b0;
            r_kdone <= 1'b0;
            r_edone <= 1'b0;
            r_round <= 4'd0;
        end else begin
            r_kdone <= 1'b0;
            r_edone <= 1'b0;
            if (i_ctl.kexp_start) begin
                r_kbusy <= 1'b1;
                r_round <= 4'd1;
            end else if (i_ctl.enc_start) begin
                r_ebusy <= 1'b1;
                r_round <= 4'd1;
            end else if (r_kbusy || r_ebusy) begin
                r_round <= r_round + 4'd1;
                if (r_round == gcm_pkg::LAST_ROUND) begin
                    r_kbusy <= 1'b0;
                    r_ebusy <= 1'b0;
                    r_kdone <= r_kbusy;
                    r_edone <= r_ebusy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.kexp_start) begin
            r_rk[0] <= i_key;
            r_kw    <= i_key;
        end else if (r_kbusy) begin
            r_rk[r_round] <= w_knext;
            r_kw          <= w_knext;
        end
        if (i_ctl.enc_start) begin
            r_st <= i_blk ^ r_rk[0];
        end else if (r_ebusy) begin
            r_st <= gcm_pkg::aes_round(r_st, r_round == gcm_pkg::LAST_ROUND) ^ r_rk[r_round];
        end
    end

endmodule

### src/gcm_ghash.sv
// ----------------------------------------------------------------------------
// gcm_ghash
// GF(2^128) multiply for GHASH, eight bits of the operand per cycle.
// ----------------------------------------------------------------------------
module gcm_ghash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [127:0]  i_a,
    input  logic [127:0]  i_h,
    output logic          o_done,
    output logic [127:0]  o_z
);

    logic [127:0] r_a;
    logic [127:0] r_v;
    logic [127:0] r_z;
    logic [3:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [127:0] w_v;
    logic [127:0] w_z;

    assign o_done = r_done;
    assign o_z    = r_z;

    always_comb begin
        w_v = r_v;
        w_z = r_z;
        for (int j = 0; j < 8; j++) begin
            if (r_a[127-j]) begin
                w_z = w_z ^ w_v;
            end
            w_v = {1'b0, w_v[127:1]} ^ (w_v[0] ? {gcm_pkg::GH_POLY, 120'h0} : 128'h0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == gcm_pkg::GH_STEPS) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_v <= i_h;
            r_z <= 128'h0;
        end else if (r_busy) begin
            r_a <= {r_a[119:0], 8'h0};
            r_v <= w_v;
            r_z <= w_z;
        end
    end

endmodule

### src/gcm_core.sv
// ----------------------------------------------------------------------------
// gcm_core
// Back end: sequences setup, counter encryption and GHASH for each queued
// item and holds the result register.
// ----------------------------------------------------------------------------
module gcm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcm_pkg::t_cfg      i_cfg,
    input  logic               i_cfg_clr,
    input  logic               i_q_valid,
    input  gcm_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output gcm_pkg::t_result   o_res
);

    gcm_pkg::t_state   r_state, n_state;
    gcm_pkg::t_item    r_item;
    gcm_pkg::t_item    w_cur;
    gcm_pkg::t_result  r_out;
    logic              r_out_valid;
    logic              r_setup_done;
    logic [127:0]      r_acc;
    logic [127:0]      r_h;
    logic [127:0]      r_tmask;
    logic [31:0]       r_ctr;
    logic [63:0]       r_aad_len;
    logic [63:0]       r_txt_len;
    logic [127:0]      r_res;
    logic              r_tag_ok;

    gcm_pkg::t_aes_ctl w_aes_ctl;
    gcm_pkg::t_aes_sts w_aes_sts;
    logic [127:0]      w_aes_blk;
    logic [127:0]      w_aes_res;
    logic              w_gh_start;
    logic [127:0]      w_gh_a;
    logic              w_gh_done;
    logic [127:0]      w_gh_z;
    logic              w_dispatch;
    logic              w_load_out;
    logic [127:0]      w_mask;
    logic [127:0]      w_din;
    logic [127:0]      w_text;
    logic [127:0]      w_tag;
    logic [63:0]       w_bits;

    assign w_cur  = (r_state == gcm_pkg::ST_IDLE) ? i_q_item : r_item;
    assign w_mask = gcm_pkg::byte_mask(w_cur.nbytes);
    assign w_din  = w_cur.data & w_mask;
    assign w_text = (w_din ^ w_aes_res) & w_mask;
    assign w_tag  = r_tmask ^ w_gh_z;
    assign w_bits = {56'h0, r_item.nbytes, 3'b000};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (!r_setup_done) begin
                        n_state = gcm_pkg::ST_KEXP;
                    end else if (i_q_item.op == gcm_pkg::OP_TEXT) begin
                        n_state = gcm_pkg::ST_CTR;
                    end else begin
                        n_state = gcm_pkg::ST_HASH;
                    end
                end
            end
            gcm_pkg::ST_KEXP: begin
                if (w_aes_sts.kexp_done) begin
                    n_state = gcm_pkg::ST_HSUB;
                end
            end
            gcm_pkg::ST_HSUB: begin
                if (w_aes_sts.enc_done) begin
                    n_state = gcm_pkg::ST_TMASK;
                end
            end
            gcm_pkg::ST_TMASK: begin
                if (w_aes_sts.enc_done) begin
                    n_state = (r_item.op == gcm_pkg::OP_TEXT) ? gcm_pkg::ST_CTR
                                                              : gcm_pkg::ST_HASH;
                end
            end
            gcm_pkg::ST_CTR: begin
                if (w_aes_sts.enc_done) begin
                    n_state = gcm_pkg::ST_HASH;
                end
            end
            gcm_pkg::ST_HASH: begin
                if (w_gh_done) begin
                    n_state = (r_item.op == gcm_pkg::OP_AAD) ? gcm_pkg::ST_IDLE
                                                             : gcm_pkg::ST_OUT;
                end
            end
            gcm_pkg::ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = gcm_pkg::ST_IDLE;
                end
            end
            default: n_state = gcm_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_q_pop              = 1'b0;
        w_aes_ctl.kexp_start = 1'b0;
        w_aes_ctl.enc_start  = 1'b0;
        w_aes_blk            = 128'h0;
        w_gh_start           = 1'b0;
        w_gh_a               = 128'h0;
        w_dispatch           = 1'b0;
        w_load_out           = 1'b0;
        case (r_state)
            gcm_pkg::ST_IDLE: begin
                o_q_pop              = i_q_valid;
                w_aes_ctl.kexp_start = i_q_valid && !r_setup_done;
                w_dispatch           = i_q_valid && r_setup_done;
            end
            gcm_pkg::ST_KEXP: begin
                w_aes_ctl.enc_start = w_aes_sts.kexp_done;
            end
            gcm_pkg::ST_HSUB: begin
                w_aes_ctl.enc_start = w_aes_sts.enc_done;
                w_aes_blk           = {i_cfg.iv, 32'd1};
            end
            gcm_pkg::ST_TMASK: begin
                w_dispatch = w_aes_sts.enc_done;
            end
            gcm_pkg::ST_CTR: begin
                w_gh_start = w_aes_sts.enc_done;
                w_gh_a     = r_acc ^ (i_cfg.decrypt ? w_din : w_text);
            end
            gcm_pkg::ST_OUT: begin
                w_load_out = !r_out_valid || i_ready;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
        if (w_dispatch) begin
            case (w_cur.op)
                gcm_pkg::OP_TEXT: begin
                    w_aes_ctl.enc_start = 1'b1;
                    w_aes_blk           = {i_cfg.iv, r_ctr + 32'd1};
                end
                gcm_pkg::OP_AAD: begin
                    w_gh_start = 1'b1;
                    w_gh_a     = r_acc ^ w_din;
                end
                default: begin
                    w_gh_start = 1'b1;
                    w_gh_a     = r_acc ^ {r_aad_len, r_txt_len};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gcm_pkg::ST_IDLE;
            r_setup_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_clr) begin
                r_setup_done <= 1'b0;
            end else if (r_state == gcm_pkg::ST_TMASK && w_aes_sts.enc_done) begin
                r_setup_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 128'h0;
            r_h       <= 128'h0;
            r_tmask   <= 128'h0;
            r_ctr     <= 32'd1;
            r_aad_len <= 64'h0;
            r_txt_len <= 64'h0;
        end else begin
            if (w_aes_ctl.kexp_start) begin
                r_acc     <= 128'h0;
                r_ctr     <= 32'd1;
                r_aad_len <= 64'h0;
                r_txt_len <= 64'h0;
            end
            if (r_state == gcm_pkg::ST_HSUB && w_aes_sts.enc_done) begin
                r_h <= w_aes_res;
            end
            if (r_state == gcm_pkg::ST_TMASK && w_aes_sts.enc_done) begin
                r_tmask <= w_aes_res;
            end
            if (w_dispatch && w_cur.op == gcm_pkg::OP_TEXT) begin
                r_ctr <= r_ctr + 32'd1;
            end
            if (r_state == gcm_pkg::ST_HASH && w_gh_done) begin
                case (r_item.op)
                    gcm_pkg::OP_AAD: begin
                        r_acc     <= w_gh_z;
                        r_aad_len <= r_aad_len + w_bits;
                    end
                    gcm_pkg::OP_TEXT: begin
                        r_acc     <= w_gh_z;
                        r_txt_len <= r_txt_len + w_bits;
                    end
                    default: begin
                        // message done, start over for the next one
                        r_acc     <= 128'h0;
                        r_ctr     <= 32'd1;
                        r_aad_len <= 64'h0;
                        r_txt_len <= 64'h0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == gcm_pkg::ST_CTR && w_aes_sts.enc_done) begin
            r_res    <= w_text;
            r_tag_ok <= 1'b1;
        end else if (r_state == gcm_pkg::ST_HASH && w_gh_done &&
                     r_item.op == gcm_pkg::OP_FIN) begin
            r_res    <= w_tag;
            r_tag_ok <= !i_cfg.decrypt || (w_tag == r_item.data);
        end
        if (w_load_out) begin
            r_out.kind   <= (r_item.op == gcm_pkg::OP_FIN);
            r_out.data   <= r_res;
            r_out.nbytes <= (r_item.op == gcm_pkg::OP_FIN) ? gcm_pkg::FULL_BYTES
                                                           : r_item.nbytes;
            r_out.tag_ok <= r_tag_ok;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    gcm_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_aes_ctl),
        .i_key    (i_cfg.key),
        .i_blk    (w_aes_blk),
        .o_sts    (w_aes_sts),
        .o_result (w_aes_res)
    );

    gcm_ghash u_ghash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gh_start),
        .i_a     (w_gh_a),
        .i_h     (r_h),
        .o_done  (w_gh_done),
        .o_z     (w_gh_z)
    );

endmodule

### src/aes128_gcm_engine.sv
// ----------------------------------------------------------------------------
// aes128_gcm_engine
// AES-128-GCM with a 96-bit IV: AAD, text and finish beats in, text and tag out.
// ----------------------------------------------------------------------------
// Usage:
//   Configure key, IV and direction through the write port while idle; a
//   write to the key, IV or mode registers forces a fresh setup (key
//   schedule, H, E(J0)) before the next item. Input beats (op, data,
//   byte_count) enter a two-entry queue on valid and ready; ready drops only
//   while that queue is full. AAD beats give no output; each text beat gives
//   one text beat, a finish beat gives the tag. Setup runs the key schedule
//   and then the two AES blocks, one round per cycle in the shared AES unit.
//   An AAD block is bound by the GHASH multiplier that folds in eight bits
//   per cycle. A text block first runs the counter block in the AES unit,
//   then GHASH; a finish runs GHASH on the length block. Results sit in an
//   output register; while the receiver stalls, the back end still finishes
//   one more text or finish item and holds it until the register frees, and
//   the queue keeps taking beats until full. Reset empties the queue and the
//   output register and clears the configuration to zero with setup pending.
// ----------------------------------------------------------------------------
module aes128_gcm_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_op,
    input  logic [63:0]  i_data_high,
    input  logic [63:0]  i_data_low,
    input  logic [4:0]   i_byte_count,
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_kind,
    output logic [63:0]  o_out_high,
    output logic [63:0]  o_out_low,
    output logic [4:0]   o_out_bytes,
    output logic         o_tag_ok
);

    gcm_pkg::t_cfg    r_cfg;
    logic             w_cfg_clr;
    gcm_pkg::t_item   w_item;
    gcm_pkg::t_item   w_q_item;
    logic             w_q_valid;
    logic             w_q_pop;
    gcm_pkg::t_result w_res;

    assign w_cfg_clr = i_cfg_we && (i_cfg_addr <= gcm_pkg::REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gcm_pkg::REG_KEY_HI: r_cfg.key[127:64] <= i_cfg_data;
                gcm_pkg::REG_KEY_LO: r_cfg.key[63:0]   <= i_cfg_data;
                gcm_pkg::REG_IV_HI:  r_cfg.iv[95:32]   <= i_cfg_data;
                gcm_pkg::REG_IV_LO:  r_cfg.iv[31:0]    <= i_cfg_data[31:0];
                gcm_pkg::REG_MODE:   r_cfg.decrypt     <= i_cfg_data[0];
                default:             r_cfg             <= r_cfg;
            endcase
        end
    end

    assign w_item.op     = i_op;
    assign w_item.data   = {i_data_high, i_data_low};
    assign w_item.nbytes = i_byte_count;

    gcm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    gcm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cfg_clr (w_cfg_clr),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_kind      = w_res.kind;
    assign o_out_high  = w_res.data[127:64];
    assign o_out_low   = w_res.data[63:0];
    assign o_out_bytes = w_res.nbytes;
    assign o_tag_ok    = w_res.tag_ok;

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_text_tag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> o_tag_ok)
        else $error("text beat without tag_ok");

    a_tag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_out_bytes == gcm_pkg::FULL_BYTES))
        else $error("tag beat not sixteen bytes");

    a_encrypt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_cfg.decrypt) |-> o_tag_ok)
        else $error("encrypt result with tag_ok low");

endmodule
